// ===== design/sorted_priority_queue_unit_macros.svh =====
// Assertion macros shared by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// Shared types and codes of the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Operation carried on s_axis_tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/sorted_priority_queue_unit.sv =====
// Output: the result of a word accepted on s_axis is registered and shows on m_axis in the next cycle.
// Throughput: one word per cycle unless m_axis stalls; each cell does one compare against the
// broadcast key and one neighbor shift per cycle, so the rate is independent of DEPTH.
// Reset: entry count and output valid clear; cell contents are left as they are
// and are only read below the entry count.
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int IN_RAW  = KEY_BITS + TAG_BITS,
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW = 2 * KEY_BITS + 2 * TAG_BITS + CNT_W + 5,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // item_key, item_tag, zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  // action
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // out_valid, out_key, out_tag, head_valid, head_key, head_tag,
  // entry_count, is_empty, is_full, dropped, zero pad
  output logic [OUT_W-1:0] m_axis_tdata
);

  // ---------------------------------------------------------------------
  // Input decode. Cell 0 is the head (smallest key); keys grow upward.
  // ---------------------------------------------------------------------
  logic [KEY_BITS-1:0] new_key;
  logic [TAG_BITS-1:0] new_tag;
  logic                accept;
  logic                is_remove;
  logic                full_q, empty_q;
  cell_ctrl_t          ctrl;

  assign new_key   = s_axis_tdata[KEY_BITS-1:0];
  assign new_tag   = s_axis_tdata[KEY_BITS +: TAG_BITS];
  assign is_remove = (s_axis_tuser == ACT_REMOVE);

  // output register takes a new word whenever it is empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [CNT_W-1:0] count_q, count_d;

  assign full_q  = (count_q == CNT_W'(DEPTH));
  assign empty_q = (count_q == '0);

  assign ctrl.do_insert = accept && !is_remove && !full_q;
  assign ctrl.do_remove = accept && is_remove && !empty_q;

  always_comb begin
    count_d = count_q;
    if (ctrl.do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.do_remove) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  logic [KEY_BITS-1:0] cell_key   [DEPTH];
  logic [TAG_BITS-1:0] cell_tag   [DEPTH];
  logic [KEY_BITS-1:0] cell_key_d [DEPTH];
  logic [TAG_BITS-1:0] cell_tag_d [DEPTH];
  logic [DEPTH-1:0]    cell_lt;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                prev_lt;
    logic [KEY_BITS-1:0] prev_key, next_key;
    logic [TAG_BITS-1:0] prev_tag, next_tag;

    if (g == 0) begin : g_first
      // nothing below the head: a new entry lands here unless it sorts later
      assign prev_lt  = 1'b1;
      assign prev_key = new_key;
      assign prev_tag = new_tag;
    end else begin : g_mid
      assign prev_lt  = cell_lt[g-1];
      assign prev_key = cell_key[g-1];
      assign prev_tag = cell_tag[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_key = '0;
      assign next_tag = '0;
    end else begin : g_inner
      assign next_key = cell_key[g+1];
      assign next_tag = cell_tag[g+1];
    end

    spq_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_key_i  (new_key),
      .new_tag_i  (new_tag),
      .occ_i      (CNT_W'(g) < count_q),
      .prev_lt_i  (prev_lt),
      .prev_key_i (prev_key),
      .prev_tag_i (prev_tag),
      .next_key_i (next_key),
      .next_tag_i (next_tag),
      .lt_o       (cell_lt[g]),
      .key_o      (cell_key[g]),
      .tag_o      (cell_tag[g]),
      .key_d_o    (cell_key_d[g]),
      .tag_d_o    (cell_tag_d[g])
    );
  end

  // ---------------------------------------------------------------------
  // Result word: removed entry is the old head, head is cell 0's next value
  // ---------------------------------------------------------------------
  logic                out_valid, head_valid, dropped;
  logic                empty_d, full_d;
  logic [KEY_BITS-1:0] out_key, head_key;
  logic [TAG_BITS-1:0] out_tag, head_tag;
  logic [OUT_W-1:0]    tdata_d;

  assign out_valid  = ctrl.do_remove;
  assign out_key    = out_valid ? cell_key[0] : '0;
  assign out_tag    = out_valid ? cell_tag[0] : '0;
  assign empty_d    = (count_d == '0);
  assign full_d     = (count_d == CNT_W'(DEPTH));
  assign head_valid = !empty_d;
  assign head_key   = head_valid ? cell_key_d[0] : '0;
  assign head_tag   = head_valid ? cell_tag_d[0] : '0;
  assign dropped    = !is_remove && full_q;

  assign tdata_d = OUT_W'({dropped, full_d, empty_d, count_d, head_tag, head_key,
                           head_valid, out_tag, out_key, out_valid});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_axis_tdata <= tdata_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/spq_cell.sv =====
// One cell of the queue chain: holds one entry, shifts toward either neighbor.
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8
) (
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [TAG_BITS-1:0] new_tag_i,
  input  logic                occ_i,       // this cell holds an entry
  input  logic                prev_lt_i,   // lower neighbor keeps its entry
  input  logic [KEY_BITS-1:0] prev_key_i,
  input  logic [TAG_BITS-1:0] prev_tag_i,
  input  logic [KEY_BITS-1:0] next_key_i,
  input  logic [TAG_BITS-1:0] next_tag_i,
  output logic                lt_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [TAG_BITS-1:0] tag_o,
  output logic [KEY_BITS-1:0] key_d_o,
  output logic [TAG_BITS-1:0] tag_d_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  // strictly smaller keys stay ahead of a new entry
  assign lt_o = occ_i && (key_q < new_key_i);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (ctrl_i.do_insert) begin
      if (!lt_o) begin
        if (prev_lt_i) begin
          key_d = new_key_i;
          tag_d = new_tag_i;
        end else begin
          key_d = prev_key_i;
          tag_d = prev_tag_i;
        end
      end
    end else if (ctrl_i.do_remove) begin
      key_d = next_key_i;
      tag_d = next_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o   = key_q;
  assign tag_o   = tag_q;
  assign key_d_o = key_d;
  assign tag_d_o = tag_d;

endmodule

`default_nettype wire

// ===== design/spq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level.
`default_nettype none
`include "sorted_priority_queue_unit_macros.svh"

module spq_checker #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int OUT_RAW = 2 * KEY_BITS + 2 * TAG_BITS + CNT_W + 5,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int HV_POS  = 1 + KEY_BITS + TAG_BITS;
  localparam int CNT_POS = HV_POS + 1 + KEY_BITS + TAG_BITS;
  localparam int EMP_POS = CNT_POS + CNT_W;

  logic out_valid, head_valid, is_empty, is_full, dropped;

  assign out_valid  = m_axis_tdata[0];
  assign head_valid = m_axis_tdata[HV_POS];
  assign is_empty   = m_axis_tdata[EMP_POS];
  assign is_full    = m_axis_tdata[EMP_POS + 1];
  assign dropped    = m_axis_tdata[EMP_POS + 2];

  `SPQ_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
  `SPQ_ASSERT_IMP(a_head_empty, m_axis_tvalid, head_valid == !is_empty, "head valid disagrees with empty")
  `SPQ_ASSERT_IMP(a_rm_no_drop, m_axis_tvalid && out_valid, !dropped && !is_full, "remove flagged drop or full")
  `SPQ_ASSERT_IMP(a_drop_full, m_axis_tvalid && dropped, is_full && !is_empty, "drop while not full")

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .DEPTH    (DEPTH),
  .KEY_BITS (KEY_BITS),
  .TAG_BITS (TAG_BITS)
) u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
